@@ rtl/aafr_pkg.sv @@
`timescale 1ns / 1ps
package aafr_pkg;

  localparam int CoordBits = 32;
  localparam int CordicStages = 24;
  localparam int CoordW = (CoordBits < 32) ? CoordBits : 32;
  localparam int Guard = 58 - CoordW;
  localparam int WordW = 64;
  localparam logic [29:0] InvGainQ30 = 30'd652032874;

  typedef logic signed [WordW-1:0] word_t;

  typedef struct packed {
    word_t vx;
    word_t vy;
    word_t px;
    word_t py;
    word_t pz;
    word_t az;
    logic  bypass;
  } cordic_t;

  function automatic word_t asr(input word_t v, input int n);
    asr = v >>> n;
  endfunction

  function automatic word_t sext(input logic [31:0] v);
    logic signed [CoordW-1:0] t;
    t = v[CoordW-1:0];
    sext = WordW'(t);
  endfunction

  function automatic logic [31:0] finish(input word_t v);
    word_t hi;
    word_t lo;
    word_t t;
    hi = (word_t'(1) <<< (CoordW - 1)) - word_t'(1);
    lo = -hi - word_t'(1);
    t = (v + (word_t'(1) <<< (Guard - 1))) >>> Guard;
    if (t > hi) t = hi;
    if (t < lo) t = lo;
    finish = t[31:0];
  endfunction

endpackage

@@ rtl/aafr_cordic_stage.sv @@
`timescale 1ns / 1ps
module aafr_cordic_stage (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic [5:0]        shift,
  input  logic              in_valid,
  input  aafr_pkg::cordic_t in_data,
  output logic              out_valid,
  output aafr_pkg::cordic_t out_data
);

  aafr_pkg::cordic_t nxt;

  always_comb begin
    nxt = in_data;
    if (!in_data.bypass) begin
      if (in_data.vy >= 0) begin
        nxt.vx = in_data.vx + aafr_pkg::asr(in_data.vy, int'(shift));
        nxt.vy = in_data.vy - aafr_pkg::asr(in_data.vx, int'(shift));
        nxt.px = in_data.px + aafr_pkg::asr(in_data.py, int'(shift));
        nxt.py = in_data.py - aafr_pkg::asr(in_data.px, int'(shift));
      end else begin
        nxt.vx = in_data.vx - aafr_pkg::asr(in_data.vy, int'(shift));
        nxt.vy = in_data.vy + aafr_pkg::asr(in_data.vx, int'(shift));
        nxt.px = in_data.px - aafr_pkg::asr(in_data.py, int'(shift));
        nxt.py = in_data.py + aafr_pkg::asr(in_data.px, int'(shift));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

@@ rtl/aafr_cordic.sv @@
`timescale 1ns / 1ps
module aafr_cordic (
  input  logic              clk,
  input  logic              rst,
  input  logic              en,
  input  logic              in_valid,
  input  aafr_pkg::cordic_t in_data,
  output logic              out_valid,
  output aafr_pkg::cordic_t out_data
);

  logic              v [aafr_pkg::CordicStages+1];
  aafr_pkg::cordic_t d [aafr_pkg::CordicStages+1];

  assign v[0] = in_valid;
  assign d[0] = in_data;

  for (genvar i = 0; i < aafr_pkg::CordicStages; i++) begin : g_stage
    aafr_cordic_stage u_stage (
      .clk(clk), .rst(rst), .en(en), .shift(6'(i)),
      .in_valid(v[i]), .in_data(d[i]),
      .out_valid(v[i+1]), .out_data(d[i+1])
    );
  end

  assign out_valid = v[aafr_pkg::CordicStages];
  assign out_data  = d[aafr_pkg::CordicStages];

endmodule

@@ rtl/aafr_gain.sv @@
`timescale 1ns / 1ps
module aafr_gain (
  input  logic            clk,
  input  logic            en,
  input  aafr_pkg::word_t in_value,
  output aafr_pkg::word_t out_value
);

  logic        neg;
  logic [63:0] mag;
  logic [63:0] hi_p;
  logic [63:0] lo_p;
  logic        neg_q;
  logic [63:0] hi_q;
  logic [63:0] lo_q;
  logic [63:0] sum;

  always_comb begin
    neg  = in_value < 0;
    mag  = neg ? 64'(-in_value) : 64'(in_value);
    hi_p = 64'({32'd0, mag[63:32]} * {34'd0, aafr_pkg::InvGainQ30});
    lo_p = 64'({32'd0, mag[31:0]} * {34'd0, aafr_pkg::InvGainQ30});
  end

  always_ff @(posedge clk) begin
    if (en) begin
      neg_q <= neg;
      hi_q  <= hi_p;
      lo_q  <= lo_p;
    end
  end

  assign sum = (hi_q << 2) + ((lo_q + 64'(1 << 29)) >> 30);

  always_ff @(posedge clk) begin
    if (en) begin
      out_value <= neg_q ? -aafr_pkg::word_t'(sum) : aafr_pkg::word_t'(sum);
    end
  end

endmodule

@@ rtl/axis_aligned_frame_rotation_core.sv @@
`timescale 1ns / 1ps
// Axis-aligned frame rotation of one point per transfer.
// Slave channel s_axis_*: one transfer carries point, axis and centre, nine
// signed Q15.16 words. Master channel m_axis_*: one transfer carries the point
// in the frame whose x axis lies along the axis direction, saturated Q15.16.
// The block subtracts the centre, rotates about Z onto the axis azimuth with a
// CORDIC pass, compensates gain, rotates about Y with a second pass and
// compensates gain again. A point passes through the entry register, the
// Z-pass CORDIC pipeline of CordicStages (24) stages, two-register gain
// multipliers, the Y-pass setup register, the Y-pass CORDIC pipeline,
// two-register gain multipliers again and the output register. Throughput
// is one point per cycle while the receiver accepts. The whole pipeline
// advances as one; when the receiver stalls with the output register full,
// every stage holds and s_axis_tready drops, and nothing is lost or repeated.
// Reset clears all valid bits and holds s_axis_tready low; the block accepts
// again as soon as rst is low.
module axis_aligned_frame_rotation_core (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // point_x, point_y, point_z, axis_x, axis_y, axis_z, centre_x, centre_y, centre_z
  input  logic [287:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // local_x, local_y, local_z
  output logic [95:0]  m_axis_tdata
);

  localparam int Gd = aafr_pkg::Guard;

  logic en;
  assign en = m_axis_tready || !m_axis_tvalid;
  assign s_axis_tready = en && !rst;

  // stage 0: difference and prerotation
  aafr_pkg::word_t ax, ay, az, dx, dy, dz;
  logic s0_valid;
  aafr_pkg::cordic_t s0;

  always_comb begin
    ax = aafr_pkg::sext(s_axis_tdata[96 +: 32]);
    ay = aafr_pkg::sext(s_axis_tdata[128 +: 32]);
    az = aafr_pkg::sext(s_axis_tdata[160 +: 32]);
    dx = (aafr_pkg::sext(s_axis_tdata[0 +: 32]) - aafr_pkg::sext(s_axis_tdata[192 +: 32])) <<< Gd;
    dy = (aafr_pkg::sext(s_axis_tdata[32 +: 32]) - aafr_pkg::sext(s_axis_tdata[224 +: 32])) <<< Gd;
    dz = (aafr_pkg::sext(s_axis_tdata[64 +: 32]) - aafr_pkg::sext(s_axis_tdata[256 +: 32])) <<< Gd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (en) begin
      s0_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s0.bypass <= (ax == 0) && (ay == 0);
      s0.vx     <= (ax < 0) ? -(ax <<< Gd) : (ax <<< Gd);
      s0.vy     <= (ax < 0) ? -(ay <<< Gd) : (ay <<< Gd);
      s0.px     <= (ax < 0) ? -dx : dx;
      s0.py     <= (ax < 0) ? -dy : dy;
      s0.pz     <= dz;
      s0.az     <= az;
    end
  end

  logic c1_valid;
  aafr_pkg::cordic_t c1;

  aafr_cordic u_cordic_z (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s0_valid), .in_data(s0),
    .out_valid(c1_valid), .out_data(c1)
  );

  // gain compensation after the Z pass
  aafr_pkg::word_t g_r, g_x, g_y;
  logic g_valid [2];
  aafr_pkg::cordic_t g_d [2];

  aafr_gain u_gain_r (.clk(clk), .en(en), .in_value(c1.vx), .out_value(g_r));
  aafr_gain u_gain_x (.clk(clk), .en(en), .in_value(c1.px), .out_value(g_x));
  aafr_gain u_gain_y (.clk(clk), .en(en), .in_value(c1.py), .out_value(g_y));

  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid[0] <= 1'b0;
      g_valid[1] <= 1'b0;
    end else if (en) begin
      g_valid[0] <= c1_valid;
      g_valid[1] <= g_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      g_d[0] <= c1;
      g_d[1] <= g_d[0];
    end
  end

  // stage: set up the Y pass
  aafr_pkg::word_t u_x, u_y, r;
  logic s1_valid;
  aafr_pkg::cordic_t s1;

  always_comb begin
    u_x = g_d[1].bypass ? g_d[1].px : g_x;
    u_y = g_d[1].bypass ? g_d[1].py : g_y;
    r   = g_d[1].bypass ? '0 : g_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= g_valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1.bypass <= (r == 0);
      s1.az     <= '0;
      s1.pz     <= u_y;
      if (r == 0) begin
        s1.vx <= '0;
        s1.vy <= '0;
        s1.px <= (g_d[1].az >= 0) ? g_d[1].pz : -g_d[1].pz;
        s1.py <= (g_d[1].az >= 0) ? -u_x : u_x;
      end else begin
        s1.vx <= r;
        s1.vy <= g_d[1].az <<< Gd;
        s1.px <= u_x;
        s1.py <= g_d[1].pz;
      end
    end
  end

  logic c2_valid;
  aafr_pkg::cordic_t c2;

  aafr_cordic u_cordic_y (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(s1_valid), .in_data(s1),
    .out_valid(c2_valid), .out_data(c2)
  );

  aafr_pkg::word_t h_x, h_z;
  logic h_valid [2];
  aafr_pkg::cordic_t h_d [2];

  aafr_gain u_gain_lx (.clk(clk), .en(en), .in_value(c2.px), .out_value(h_x));
  aafr_gain u_gain_lz (.clk(clk), .en(en), .in_value(c2.py), .out_value(h_z));

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid[0] <= 1'b0;
      h_valid[1] <= 1'b0;
    end else if (en) begin
      h_valid[0] <= c2_valid;
      h_valid[1] <= h_valid[0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      h_d[0] <= c2;
      h_d[1] <= h_d[0];
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (en) begin
      m_axis_tvalid <= h_valid[1];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_axis_tdata[0 +: 32]  <= aafr_pkg::finish(h_d[1].bypass ? h_d[1].px : h_x);
      m_axis_tdata[32 +: 32] <= aafr_pkg::finish(h_d[1].pz);
      m_axis_tdata[64 +: 32] <= aafr_pkg::finish(h_d[1].bypass ? h_d[1].py : h_z);
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output changed under stall");

  a_ready: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("ready low with empty output");

  a_latency: assert property (@(posedge clk) disable iff (rst)
    s_axis_tvalid && s_axis_tready && m_axis_tready |=> s0_valid)
    else $error("accepted transfer lost at entry");

endmodule
